### rtl/core/npos_pkg.sv
// ----------------------------------------------------------------------------
// npos_pkg: shared types and constants
// Segment record, opcodes, status codes and shared-unit control for the
// nearest-point-on-segments block.
// ----------------------------------------------------------------------------
`default_nettype none

package npos_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;

    localparam int COORD_W = 15;   // coordinate width, signed mm
    localparam int MUL_A_W = 34;   // shared multiplier operand a
    localparam int MUL_B_W = 21;   // shared multiplier operand b
    localparam int ACC_W   = MUL_A_W + MUL_B_W;
    localparam int LEN2_W  = 32;   // squared length, unsigned
    localparam int NUM_W   = 33;   // projection numerator, signed
    localparam int DIVN_W  = 48;   // rounded dividend magnitude
    localparam int QUO_W   = 18;   // quotient bits per division
    localparam int PROJ_W  = 20;   // projected coordinate, signed
    localparam int DIST_W  = 42;   // squared distance, unsigned

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } seg_t;

    typedef enum logic [2:0] {
        ALU_HOLD     = 3'd0,
        ALU_MUL      = 3'd1,
        ALU_MAC      = 3'd2,
        ALU_DIV_INIT = 3'd3,
        ALU_DIV_STEP = 3'd4
    } alu_op_t;

    typedef struct packed {
        alu_op_t                   op;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        logic [LEN2_W-1:0]         dvsr;
    } alu_ctrl_t;

    // c lies between u and v, inclusive, in either order
    function automatic logic between(input logic signed [PROJ_W-1:0] c,
                                     input logic signed [COORD_W-1:0] u,
                                     input logic signed [COORD_W-1:0] v);
        logic signed [PROJ_W-1:0] ue;
        logic signed [PROJ_W-1:0] ve;
        ue = PROJ_W'(u);
        ve = PROJ_W'(v);
        return ((c >= ue) && (c <= ve)) || ((c >= ve) && (c <= ue));
    endfunction

endpackage

`default_nettype wire

### rtl/core/npos_table.sv
// ----------------------------------------------------------------------------
// npos_table: segment store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module npos_table #(
    parameter int DEPTH = npos_pkg::MAX_SEGMENTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire npos_pkg::seg_t  wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output npos_pkg::seg_t       rdata
);

    npos_pkg::seg_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/npos_alu.sv
// ----------------------------------------------------------------------------
// npos_alu: shared arithmetic unit
// Multiply / multiply-accumulate and a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module npos_alu (
    input  wire logic                              clk,
    input  wire npos_pkg::alu_ctrl_t               ctrl,
    output logic signed [npos_pkg::ACC_W-1:0]      acc,
    output logic [npos_pkg::QUO_W-1:0]             quo
);

    localparam int AW = npos_pkg::ACC_W;
    localparam int QW = npos_pkg::QUO_W;
    localparam int LW = npos_pkg::LEN2_W;
    localparam int NW = npos_pkg::DIVN_W;

    logic signed [AW-1:0] acc_reg, acc_next;
    logic [LW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        nsh_reg, nsh_next;
    logic [QW-1:0]        quo_reg, quo_next;

    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] mag;
    logic [NW-1:0]        dvd;
    logic [LW:0]          trial;

    always_comb
    begin
        prod     = AW'(ctrl.a) * AW'(ctrl.b);
        mag      = acc_reg[AW-1] ? -acc_reg : acc_reg;
        dvd      = mag[NW-1:0] + NW'(ctrl.dvsr[LW-1:1]);
        trial    = {rem_reg, nsh_reg[QW-1]};
        acc_next = acc_reg;
        rem_next = rem_reg;
        nsh_next = nsh_reg;
        quo_next = quo_reg;
        case (ctrl.op)
            npos_pkg::ALU_MUL:
            begin
                acc_next = prod;
            end
            npos_pkg::ALU_MAC:
            begin
                acc_next = acc_reg + prod;
            end
            npos_pkg::ALU_DIV_INIT:
            begin
                // quotient fits QW bits, so the upper part starts below the divisor
                rem_next = LW'(dvd[NW-1:QW]);
                nsh_next = dvd[QW-1:0];
                quo_next = '0;
            end
            npos_pkg::ALU_DIV_STEP:
            begin
                nsh_next = {nsh_reg[QW-2:0], 1'b0};
                if (trial >= {1'b0, ctrl.dvsr})
                begin
                    rem_next = LW'(trial - {1'b0, ctrl.dvsr});
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[LW-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
        quo_reg <= quo_next;
    end

    assign acc = acc_reg;
    assign quo = quo_reg;

endmodule

`default_nettype wire

### rtl/core/nearest_point_on_segments.sv
// ----------------------------------------------------------------------------
// nearest_point_on_segments: nearest point on a stored set of 2D segments
// Keeps a segment table and answers nearest-point queries in integer mm.
// ----------------------------------------------------------------------------
// Each input transfer carries an opcode: clear the table, append one segment
// (ax,ay)-(bx,by), or query the point (ax,ay). Every transfer yields exactly
// one result transfer (status, near_x, near_y). Clear, append and the unused
// opcode go from acceptance straight to the output state. A query walks the
// stored segments in order through one shared multiply-accumulate /
// restoring-divide unit: per segment a table read (fetch, then load), twelve
// multiply steps, two divisions for the rounded projection, a set step and a
// pick step. A zero-length segment skips the divisions and the projection
// distance. item_stall is high from acceptance until the result has been
// loaded into the output register; the output register then holds the result
// until result_stall drops, while the next item may already be taken.
// Projections round to nearest with halves away from zero; a projection
// outside the endpoints' bounding box falls back to the nearer endpoint (start
// wins ties), and a zero-length segment uses its start point. Among segments
// the strictly smaller squared distance wins, so earlier entries keep ties.
// Status: 0 ok, 1 append refused (table full), 2 query on an empty table;
// near_x/near_y are -1 whenever there is no point to report.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_on_segments #(
    parameter int MAX_SEGMENTS = npos_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input item channel
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic [1:0]                            opcode,
    input  wire logic signed [npos_pkg::COORD_W-1:0]   ax,
    input  wire logic signed [npos_pkg::COORD_W-1:0]   ay,
    input  wire logic signed [npos_pkg::COORD_W-1:0]   bx,
    input  wire logic signed [npos_pkg::COORD_W-1:0]   by,
    // result channel
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic [1:0]                                 status,
    output logic signed [npos_pkg::COORD_W-1:0]        near_x,
    output logic signed [npos_pkg::COORD_W-1:0]        near_y
);

    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int XW  = npos_pkg::COORD_W;
    localparam int QW  = npos_pkg::QUO_W;
    localparam int PW  = npos_pkg::PROJ_W;
    localparam int DW  = npos_pkg::DIST_W;
    localparam int LW  = npos_pkg::LEN2_W;
    localparam int NW  = npos_pkg::NUM_W;
    localparam int MAW = npos_pkg::MUL_A_W;
    localparam int MBW = npos_pkg::MUL_B_W;
    localparam int SW  = $clog2(QW);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_FETCH   = 22'h000002,
        S_LOAD    = 22'h000004,
        S_LEN_A   = 22'h000008,
        S_LEN_B   = 22'h000010,
        S_NUM_A   = 22'h000020,
        S_NUM_B   = 22'h000040,
        S_PX_MUL  = 22'h000080,
        S_PX_INIT = 22'h000100,
        S_PX_DIV  = 22'h000200,
        S_PY_MUL  = 22'h000400,
        S_PY_INIT = 22'h000800,
        S_PY_DIV  = 22'h001000,
        S_PY_SET  = 22'h002000,
        S_DP_A    = 22'h004000,
        S_DP_B    = 22'h008000,
        S_DA_A    = 22'h010000,
        S_DA_B    = 22'h020000,
        S_DB_A    = 22'h040000,
        S_DB_B    = 22'h080000,
        S_PICK    = 22'h100000,
        S_OUT     = 22'h200000
    } state_t;

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           have_reg, have_next;
    logic           res_valid_reg, res_valid_next;

    // working payload
    logic signed [XW-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    npos_pkg::seg_t         seg_reg, seg_next;
    logic signed [XW:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic signed [XW:0]     vx_reg, vx_next, vy_reg, vy_next;
    logic [LW-1:0]          len2_reg, len2_next;
    logic signed [NW-1:0]   num_reg, num_next;
    logic                   zlen_reg, zlen_next;
    logic                   qneg_reg, qneg_next;
    logic signed [PW-1:0]   px_reg, px_next, py_reg, py_next;
    logic [DW-1:0]          dp_reg, dp_next, da_reg, da_next;
    logic [DW-1:0]          best_reg, best_next;
    logic [1:0]             pst_reg, pst_next;
    logic signed [XW-1:0]   pnx_reg, pnx_next, pny_reg, pny_next;
    logic [1:0]             res_st_reg, res_st_next;
    logic signed [XW-1:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;

    // shared unit and table
    npos_pkg::alu_ctrl_t        alu_ctrl;
    logic signed [npos_pkg::ACC_W-1:0] alu_acc;
    logic [QW-1:0]              alu_quo;
    logic                       tbl_we, tbl_re;
    npos_pkg::seg_t             tbl_wdata, tbl_rdata;

    // helpers for the projection, distance and pick steps
    logic signed [PW-1:0]   qsigned;
    logic signed [PW-1:0]   base;
    logic signed [MBW-1:0]  diff;
    logic                   on_seg;
    logic [DW-1:0]          cand_d;
    logic signed [XW-1:0]   cand_x, cand_y;
    logic                   item_take;

    npos_alu u_alu (
        .clk  (clk),
        .ctrl (alu_ctrl),
        .acc  (alu_acc),
        .quo  (alu_quo)
    );

    npos_table #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (tbl_rdata)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign tbl_wdata  = '{ax: ax, ay: ay, bx: bx, by: by};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        have_next      = have_reg;
        res_valid_next = res_valid_reg;
        qx_next   = qx_reg;   qy_next   = qy_reg;
        seg_next  = seg_reg;
        dx_next   = dx_reg;   dy_next   = dy_reg;
        vx_next   = vx_reg;   vy_next   = vy_reg;
        len2_next = len2_reg; num_next  = num_reg;
        zlen_next = zlen_reg; qneg_next = qneg_reg;
        px_next   = px_reg;   py_next   = py_reg;
        dp_next   = dp_reg;   da_next   = da_reg;
        best_next = best_reg;
        pst_next  = pst_reg;  pnx_next  = pnx_reg; pny_next = pny_reg;
        res_st_next = res_st_reg;
        res_x_next  = res_x_reg;
        res_y_next  = res_y_reg;

        tbl_we = 1'b0;
        tbl_re = 1'b0;
        alu_ctrl.op   = npos_pkg::ALU_HOLD;
        alu_ctrl.a    = '0;
        alu_ctrl.b    = '0;
        alu_ctrl.dvsr = len2_reg;

        qsigned = qneg_reg ? -PW'(alu_quo) : PW'(alu_quo);
        base    = '0;
        diff    = '0;
        on_seg  = !zlen_reg
                  && npos_pkg::between(px_reg, seg_reg.ax, seg_reg.bx)
                  && npos_pkg::between(py_reg, seg_reg.ay, seg_reg.by);
        cand_d  = alu_acc[DW-1:0];
        cand_x  = seg_reg.bx;
        cand_y  = seg_reg.by;

        // output register frees up when its transfer completes
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    qx_next  = ax;
                    qy_next  = ay;
                    pst_next = npos_pkg::ST_OK;
                    pnx_next = '1;
                    pny_next = '1;
                    state_next = S_OUT;
                    case (opcode)
                        npos_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        npos_pkg::OP_APPEND:
                        begin
                            if (cnt_reg >= CW'(MAX_SEGMENTS))
                            begin
                                pst_next = npos_pkg::ST_FULL;
                            end
                            else
                            begin
                                tbl_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        npos_pkg::OP_QUERY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pst_next = npos_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                have_next  = 1'b0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                tbl_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                seg_next   = tbl_rdata;
                dx_next    = (XW+1)'(tbl_rdata.bx) - (XW+1)'(tbl_rdata.ax);
                dy_next    = (XW+1)'(tbl_rdata.by) - (XW+1)'(tbl_rdata.ay);
                vx_next    = (XW+1)'(qx_reg) - (XW+1)'(tbl_rdata.ax);
                vy_next    = (XW+1)'(qy_reg) - (XW+1)'(tbl_rdata.ay);
                state_next = S_LEN_A;
            end
            S_LEN_A:
            begin
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(dx_reg);
                alu_ctrl.b  = MBW'(dx_reg);
                state_next  = S_LEN_B;
            end
            S_LEN_B:
            begin
                alu_ctrl.op = npos_pkg::ALU_MAC;
                alu_ctrl.a  = MAW'(dy_reg);
                alu_ctrl.b  = MBW'(dy_reg);
                state_next  = S_NUM_A;
            end
            S_NUM_A:
            begin
                len2_next   = alu_acc[LW-1:0];
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(vx_reg);
                alu_ctrl.b  = MBW'(dx_reg);
                state_next  = S_NUM_B;
            end
            S_NUM_B:
            begin
                alu_ctrl.op = npos_pkg::ALU_MAC;
                alu_ctrl.a  = MAW'(vy_reg);
                alu_ctrl.b  = MBW'(dy_reg);
                state_next  = S_PX_MUL;
            end
            S_PX_MUL:
            begin
                num_next  = alu_acc[NW-1:0];
                zlen_next = (len2_reg == '0);
                if (len2_reg == '0)
                begin
                    // degenerate segment: endpoints only, no division
                    state_next = S_DA_A;
                end
                else
                begin
                    alu_ctrl.op = npos_pkg::ALU_MUL;
                    alu_ctrl.a  = MAW'(alu_acc[NW-1:0]);
                    alu_ctrl.b  = MBW'(dx_reg);
                    state_next  = S_PX_INIT;
                end
            end
            S_PX_INIT, S_PY_INIT:
            begin
                qneg_next   = alu_acc[npos_pkg::ACC_W-1];
                alu_ctrl.op = npos_pkg::ALU_DIV_INIT;
                step_next   = '0;
                state_next  = (state_reg == S_PX_INIT) ? S_PX_DIV : S_PY_DIV;
            end
            S_PX_DIV, S_PY_DIV:
            begin
                alu_ctrl.op = npos_pkg::ALU_DIV_STEP;
                step_next   = step_reg + SW'(1);
                if (step_reg == SW'(QW - 1))
                begin
                    state_next = (state_reg == S_PX_DIV) ? S_PY_MUL : S_PY_SET;
                end
            end
            S_PY_MUL:
            begin
                base        = PW'(seg_reg.ax);
                px_next     = base + qsigned;
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(num_reg);
                alu_ctrl.b  = MBW'(dy_reg);
                state_next  = S_PY_INIT;
            end
            S_PY_SET:
            begin
                base       = PW'(seg_reg.ay);
                py_next    = base + qsigned;
                state_next = S_DP_A;
            end
            S_DP_A:
            begin
                diff        = MBW'(px_reg) - MBW'(qx_reg);
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_DP_B;
            end
            S_DP_B:
            begin
                diff        = MBW'(py_reg) - MBW'(qy_reg);
                alu_ctrl.op = npos_pkg::ALU_MAC;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_DA_A;
            end
            S_DA_A:
            begin
                dp_next     = alu_acc[DW-1:0];
                diff        = MBW'(seg_reg.ax) - MBW'(qx_reg);
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_DA_B;
            end
            S_DA_B:
            begin
                diff        = MBW'(seg_reg.ay) - MBW'(qy_reg);
                alu_ctrl.op = npos_pkg::ALU_MAC;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_DB_A;
            end
            S_DB_A:
            begin
                da_next     = alu_acc[DW-1:0];
                diff        = MBW'(seg_reg.bx) - MBW'(qx_reg);
                alu_ctrl.op = npos_pkg::ALU_MUL;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_DB_B;
            end
            S_DB_B:
            begin
                diff        = MBW'(seg_reg.by) - MBW'(qy_reg);
                alu_ctrl.op = npos_pkg::ALU_MAC;
                alu_ctrl.a  = MAW'(diff);
                alu_ctrl.b  = diff;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                // candidate: projection, else nearer endpoint (start on tie)
                if (on_seg)
                begin
                    cand_d = dp_reg;
                    cand_x = px_reg[XW-1:0];
                    cand_y = py_reg[XW-1:0];
                end
                else if (da_reg <= alu_acc[DW-1:0])
                begin
                    cand_d = da_reg;
                    cand_x = seg_reg.ax;
                    cand_y = seg_reg.ay;
                end
                if (!have_reg || (cand_d < best_reg))
                begin
                    have_next = 1'b1;
                    best_next = cand_d;
                    pnx_next  = cand_x;
                    pny_next  = cand_y;
                end
                if ((idx_reg + CW'(1)) == cnt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FETCH;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_st_next    = pst_reg;
                    res_x_next     = pnx_reg;
                    res_y_next     = pny_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qx_reg   <= qx_next;   qy_reg   <= qy_next;
        seg_reg  <= seg_next;
        dx_reg   <= dx_next;   dy_reg   <= dy_next;
        vx_reg   <= vx_next;   vy_reg   <= vy_next;
        len2_reg <= len2_next; num_reg  <= num_next;
        zlen_reg <= zlen_next; qneg_reg <= qneg_next;
        px_reg   <= px_next;   py_reg   <= py_next;
        dp_reg   <= dp_next;   da_reg   <= da_next;
        best_reg <= best_next;
        pst_reg  <= pst_next;  pnx_reg  <= pnx_next; pny_reg <= pny_next;
        res_st_reg <= res_st_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_st_reg;
    assign near_x       = res_x_reg;
    assign near_y       = res_y_reg;

`ifndef ASSERT_OFF
    // fill count never passes the table depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count exceeds table depth");

    // the walk only reads stored entries
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (idx_reg < cnt_reg))
        else $error("table read beyond stored segments");

    // a query on a non-empty table starts the walk
    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && (opcode == npos_pkg::OP_QUERY) && (cnt_reg != '0))
        |=> (state_reg == S_FETCH))
        else $error("query did not start the table walk");

    // an empty-table status always carries the no-point marker
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_st_reg == npos_pkg::ST_EMPTY))
        |-> ((res_x_reg == '1) && (res_y_reg == '1)))
        else $error("empty-table result without -1 point");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for nearest_point_on_segments
// Sends clear, append, query and unused-opcode transfers, predicts every
// result with its own model of the segment table. Each result transfer is
// checked field by field, in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH = npos_pkg::MAX_SEGMENTS_DEF;
    localparam int RANDOM_ITEMS = 1800;

    typedef logic signed [npos_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        npos_pkg::status_t status;
        coord_t  x;
        coord_t  y;
    } near_result_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [1:0] opcode;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    logic       result_valid;
    logic       result_stall;
    logic [1:0] status;
    coord_t     near_x;
    coord_t     near_y;

    nearest_point_on_segments uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .ax           (ax),
        .ay           (ay),
        .bx           (bx),
        .by           (by),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .near_x       (near_x),
        .near_y       (near_y)
    );

    // ---------------------------------------------------------------
    // Clock: 8 ns period
    // ---------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: own copy of the segment table
    // ---------------------------------------------------------------
    npos_pkg::seg_t seg_store [TABLE_DEPTH];
    int           seg_count;
    near_result_t pending_results [$];
    int           error_count;
    bit           no_idle;       // stretches with no gaps on the input side

    // rounds q/d to nearest, halves away from zero; d > 0
    function automatic longint round_half_away(longint q, longint d);
        if (q >= 0)
            return (q + d / 2) / d;
        return -((-q + d / 2) / d);
    endfunction

    function automatic bit in_span(longint c, longint u, longint v);
        return (c >= u && c <= v) || (c >= v && c <= u);
    endfunction

    function automatic longint dist_sq(longint x0, longint y0, longint x1, longint y1);
        return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
    endfunction

    // nearest point over the stored table for query point (qx,qy)
    function automatic near_result_t nearest_on_table(longint qx, longint qy);
        near_result_t r;
        longint best, cx, cy, cand_dist, sx, sy, ex, ey, dx, dy, len2, num, px, py, da, db;
        bit have, on_seg;
        have = 0;
        best = 0;
        r.status = npos_pkg::ST_OK;
        r.x = '1;
        r.y = '1;
        for (int i = 0; i < seg_count; i++)
        begin
            sx = longint'(seg_store[i].ax);
            sy = longint'(seg_store[i].ay);
            ex = longint'(seg_store[i].bx);
            ey = longint'(seg_store[i].by);
            dx = ex - sx;
            dy = ey - sy;
            len2 = dx * dx + dy * dy;
            on_seg = 0;
            if (len2 != 0)
            begin
                num = (qx - sx) * dx + (qy - sy) * dy;
                px = sx + round_half_away(num * dx, len2);
                py = sy + round_half_away(num * dy, len2);
                if (in_span(px, sx, ex) && in_span(py, sy, ey))
                begin
                    on_seg = 1;
                    cx = px;
                    cy = py;
                    cand_dist = dist_sq(px, py, qx, qy);
                end
            end
            if (!on_seg)
            begin
                // fall back to nearer endpoint, start wins a tie
                da = dist_sq(sx, sy, qx, qy);
                db = dist_sq(ex, ey, qx, qy);
                if (da <= db)
                begin
                    cx = sx; cy = sy; cand_dist = da;
                end
                else
                begin
                    cx = ex; cy = ey; cand_dist = db;
                end
            end
            if (!have || cand_dist < best)
            begin
                have = 1;
                best = cand_dist;
                r.x = coord_t'(cx);
                r.y = coord_t'(cy);
            end
        end
        return r;
    endfunction

    // applies one accepted transfer to the table and returns its result
    function automatic near_result_t apply_item(logic [1:0] op, coord_t a_x, coord_t a_y,
                                                coord_t b_x, coord_t b_y);
        near_result_t r;
        r.status = npos_pkg::ST_OK;
        r.x = '1;
        r.y = '1;
        case (npos_pkg::opcode_t'(op))
            npos_pkg::OP_CLEAR:  seg_count = 0;
            npos_pkg::OP_APPEND:
            begin
                if (seg_count >= TABLE_DEPTH)
                    r.status = npos_pkg::ST_FULL;
                else
                begin
                    seg_store[seg_count] = '{ax: a_x, ay: a_y, bx: b_x, by: b_y};
                    seg_count++;
                end
            end
            npos_pkg::OP_QUERY:
            begin
                if (seg_count == 0)
                    r.status = npos_pkg::ST_EMPTY;
                else
                    r = nearest_on_table(longint'(a_x), longint'(a_y));
            end
            default: ;   // unused opcode: no state change
        endcase
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t pick_coord(bit wide);
        if (wide)
            return coord_t'($urandom_range(0, 32767));
        return coord_t'(int'($urandom_range(0, 40)) - 20);
    endfunction

    // ---------------------------------------------------------------
    // Sender: call right after a rising edge; returns right after the
    // edge that accepted the transfer (plus any gap)
    // ---------------------------------------------------------------
    task automatic send_item(logic [1:0] op, coord_t a_x, coord_t a_y,
                             coord_t b_x, coord_t b_y);
        int gap;
        near_result_t exp_res;
        item_valid <= 1'b1;
        opcode     <= op;
        ax         <= a_x;
        ay         <= a_y;
        bx         <= b_x;
        by         <= b_y;
        do
            @(posedge clk);
        while (item_stall);
        exp_res = apply_item(op, a_x, a_y, b_x, b_y);
        pending_results = {pending_results, exp_res};
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Result checker and result-side stall generator
    // ---------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        near_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result transfer", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (near_x !== want.x)
                        report_mismatch("near_x", near_x, want.x);
                    if (near_y !== want.y)
                        report_mismatch("near_y", near_y, want.y);
                end
            end
            // stalls: bursts of random length, with quiet stretches between
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 15)
            begin
                stall_left <= pick_gap();
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // extremes, every opcode, rounding halves, degenerate segments, ties
    task automatic test_directed();
        send_item(npos_pkg::OP_QUERY, 0, 0, 0, 0);                 // empty table
        send_item(npos_pkg::OP_NONE, -16384, 16383, -1, 0);        // unused opcode
        send_item(npos_pkg::OP_APPEND, 5, -7, 5, -7);              // zero length
        send_item(npos_pkg::OP_QUERY, 100, 100, 0, 0);
        send_item(npos_pkg::OP_APPEND, -16384, -16384, 16383, 16383);
        send_item(npos_pkg::OP_QUERY, 16383, -16384, -16384, 16383);
        send_item(npos_pkg::OP_QUERY, -16384, -16384, 16383, 16383);
        send_item(npos_pkg::OP_CLEAR, 16383, 16383, 16383, 16383);
        send_item(npos_pkg::OP_APPEND, 0, 0, 2, 2);                // half rounds up
        send_item(npos_pkg::OP_QUERY, 1, 0, 0, 0);
        send_item(npos_pkg::OP_CLEAR, 0, 0, 0, 0);
        send_item(npos_pkg::OP_APPEND, 2, 2, -2, -2);              // negative halves
        send_item(npos_pkg::OP_QUERY, -1, 0, 0, 0);
        send_item(npos_pkg::OP_QUERY, 0, -1, 0, 0);
        send_item(npos_pkg::OP_APPEND, -2, -2, 2, 2);              // same line, later: tie kept
        send_item(npos_pkg::OP_QUERY, 3, -3, 0, 0);
        send_item(npos_pkg::OP_APPEND, 0, 10, 10, 10);             // projection outside box
        send_item(npos_pkg::OP_QUERY, 20, 12, 0, 0);
        send_item(npos_pkg::OP_QUERY, 5, 0, 0, 0);                 // equidistant endpoints
        send_item(npos_pkg::OP_APPEND, 16383, -16384, -16384, 16383);
        send_item(npos_pkg::OP_QUERY, 16383, 16383, 0, 0);
        send_item(npos_pkg::OP_QUERY, 1, 2, 3, 4);
        send_item(npos_pkg::OP_CLEAR, -16384, -16384, -16384, -16384);
    endtask

    // fill the table, refuse extra appends, query the full table
    task automatic test_table_full();
        send_item(npos_pkg::OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(npos_pkg::OP_APPEND, pick_coord(i[0]), pick_coord(1),
                      pick_coord(i[1]), pick_coord(1));
        send_item(npos_pkg::OP_APPEND, 1, 1, 2, 2);
        send_item(npos_pkg::OP_APPEND, -16384, 16383, 16383, -16384);
        for (int i = 0; i < 3; i++)
            send_item(npos_pkg::OP_QUERY, pick_coord(1), pick_coord(1), pick_coord(1),
                      pick_coord(1));
        send_item(npos_pkg::OP_CLEAR, 0, 0, 0, 0);
    endtask

    // mostly well-formed clear/append/query runs, the rest noise
    task automatic test_random();
        int sent, n_seg, n_query;
        bit wide;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            wide = $urandom_range(0, 1);
            if ($urandom_range(0, 99) < 85)
            begin
                send_item(npos_pkg::OP_CLEAR, pick_coord(1), pick_coord(1), pick_coord(1),
                          pick_coord(1));
                n_seg = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 70)
                                                     : $urandom_range(1, 6);
                n_query = $urandom_range(1, 4);
                for (int i = 0; i < n_seg; i++)
                    send_item(npos_pkg::OP_APPEND, pick_coord(wide), pick_coord(wide),
                              pick_coord(wide), pick_coord(wide));
                for (int i = 0; i < n_query; i++)
                    send_item(npos_pkg::OP_QUERY, pick_coord(wide), pick_coord(wide),
                              pick_coord(1), pick_coord(1));
                sent += 1 + n_seg + n_query;
            end
            else
            begin
                send_item(2'($urandom_range(0, 3)), pick_coord(1), pick_coord(1),
                          pick_coord(1), pick_coord(1));
                sent++;
            end
        end
        no_idle = 0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        opcode       = npos_pkg::OP_CLEAR;
        ax           = '0;
        ay           = '0;
        bx           = '0;
        by           = '0;
        result_stall = 1'b0;
        stall_left   = 0;
        seg_count    = 0;
        error_count  = 0;
        no_idle      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random();

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
